// File: src/vfs_pkg.sv
// Shared types and constants for the visual follow steering block.
package vfs_pkg;

   localparam int GAIN_BITS     = 16;
   localparam int BAND_BITS     = 13;
   localparam int Q15_BITS      = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int AREA_SHIFT    = 15;
   localparam int TURN_SHIFT    = 17;

   localparam logic [Q15_BITS-1:0] STOP_FRAC_RESET = 16'h8000;
   localparam logic [Q15_BITS-1:0] Q15_POS_MAX     = 16'h7FFF;
   localparam logic [Q15_BITS-1:0] Q15_NEG_MAX     = 16'h8000;
   localparam logic [Q15_BITS-1:0] Q15_ZERO        = 16'h0000;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_GAIN_NEAR    = 3'd0,
      CSR_GAIN_FAR     = 3'd1,
      CSR_STOP_FRAC    = 3'd2,
      CSR_FORWARD_FRAC = 3'd3,
      CSR_DEADBAND     = 3'd4,
      CSR_GAIN_SWITCH  = 3'd5,
      CSR_MAX_SPEED    = 3'd6,
      CSR_TURN_BLEND   = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic        [GAIN_BITS-1:0] gain_near;
      logic        [GAIN_BITS-1:0] gain_far;
      logic        [Q15_BITS-1:0]  stop_area_frac;
      logic signed [Q15_BITS-1:0]  forward_frac;
      logic        [BAND_BITS-1:0] deadband_half_px;
      logic        [BAND_BITS-1:0] gain_switch_half_px;
      logic signed [Q15_BITS-1:0]  max_speed;
      logic        [Q15_BITS-1:0]  turn_blend;
   } cfg_type;

endpackage

// File: src/vfs_req_if.sv
// Request channel carrying image size and tracked box corners.
interface vfs_req_if #(parameter int COORD_BITS = 12);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] img_width;
   logic [COORD_BITS-1:0] img_height;
   logic [COORD_BITS-1:0] left_x;
   logic [COORD_BITS-1:0] top_y;
   logic [COORD_BITS-1:0] right_x;
   logic [COORD_BITS-1:0] bottom_y;

   modport source (output valid, img_width, img_height, left_x, top_y, right_x, bottom_y,
                   input ready);
   modport sink (input valid, img_width, img_height, left_x, top_y, right_x, bottom_y,
                 output ready);
endinterface

// File: src/vfs_rsp_if.sv
// Response channel carrying the steering commands.
interface vfs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] turn_cmd;
   logic signed [15:0] forward_cmd;
   logic signed [15:0] speed_cmd;

   modport source (output valid, turn_cmd, forward_cmd, speed_cmd, input ready);
   modport sink (input valid, turn_cmd, forward_cmd, speed_cmd, output ready);
endinterface

// File: src/vfs_csr.sv
// Configuration register bank for the steering block.
module vfs_csr
   import vfs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_GAIN_NEAR:    cfg_in.gain_near           = csr_data[GAIN_BITS-1:0];
            CSR_GAIN_FAR:     cfg_in.gain_far            = csr_data[GAIN_BITS-1:0];
            CSR_STOP_FRAC:    cfg_in.stop_area_frac      = csr_data[Q15_BITS-1:0];
            CSR_FORWARD_FRAC: cfg_in.forward_frac        = $signed(csr_data[Q15_BITS-1:0]);
            CSR_DEADBAND:     cfg_in.deadband_half_px    = csr_data[BAND_BITS-1:0];
            CSR_GAIN_SWITCH:  cfg_in.gain_switch_half_px = csr_data[BAND_BITS-1:0];
            CSR_MAX_SPEED:    cfg_in.max_speed           = $signed(csr_data[Q15_BITS-1:0]);
            CSR_TURN_BLEND:   cfg_in.turn_blend          = csr_data[Q15_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{gain_near:           '0,
                     gain_far:            '0,
                     stop_area_frac:      STOP_FRAC_RESET,
                     forward_frac:        '0,
                     deadband_half_px:    '0,
                     gain_switch_half_px: '0,
                     max_speed:           '0,
                     turn_blend:          '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/visual_follow_steering.sv
// Top level of the visual follow steering pipeline.
//
//   channel    dir   handshake         content
//   req_chan   in    valid/ready       image size, box corners (COORD_BITS each)
//   rsp_chan   out   valid/ready       turn, forward, speed (signed Q1.15)
//   csr_*      in    write enable      register index, 16-bit write data
//
// Four register stages: offsets, products, scaled products, result register.
// One item per cycle while rsp_chan is ready; rsp valid once the item reaches the result register.
// Each stage holds its item while the one after it is full and stalled; a free
// stage takes the next item, so bubbles close up under back-pressure.
// Synchronous reset clears the valid bits and loads the register defaults.
module visual_follow_steering
   import vfs_pkg::*;
#(
   parameter int COORD_BITS = 12
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data,
   vfs_req_if.sink                  req_chan,
   vfs_rsp_if.source                rsp_chan
);

   localparam int C   = COORD_BITS;
   localparam int CW  = (C + 1 > BAND_BITS) ? C + 1 : BAND_BITS;
   localparam int BAW = 2 * C + 2;
   localparam int IAW = 2 * C;
   localparam int RHW = IAW + Q15_BITS;
   localparam int LW  = BAW + AREA_SHIFT + 1;
   localparam int PW  = C + GAIN_BITS + 3;
   localparam int SW  = PW + Q15_BITS + 1;
   localparam int MW  = SW - TURN_SHIFT;

   cfg_type cfg;

   vfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   logic en1, en2, en3, en4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   assign en4 = !v4_ff || rsp_chan.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;

   logic req_take;
   assign req_take = req_chan.valid && req_chan.ready;

   // stage 1: differences, offset, gain select
   logic signed [C:0]   bdx_in, bdy_in;
   logic signed [C+1:0] dx2_in, ndx2;
   logic        [C:0]   adx;
   logic [GAIN_BITS-1:0] gain_in;
   logic                rz_in;

   assign bdx_in = $signed({1'b0, req_chan.right_x}) - $signed({1'b0, req_chan.left_x});
   assign bdy_in = $signed({1'b0, req_chan.bottom_y}) - $signed({1'b0, req_chan.top_y});
   assign dx2_in = $signed({2'b00, req_chan.left_x}) + $signed({2'b00, req_chan.right_x})
                   - $signed({2'b00, req_chan.img_width});
   assign ndx2   = -dx2_in;
   assign adx    = dx2_in[C+1] ? ndx2[C:0] : dx2_in[C:0];
   assign gain_in = (CW'(adx) > CW'(cfg.gain_switch_half_px)) ? cfg.gain_far : cfg.gain_near;
   assign rz_in  = (CW'(adx) < CW'(cfg.deadband_half_px)) || (gain_in == '0)
                   || (dx2_in == '0);

   logic signed [C:0]    bdx_ff, bdy_ff;
   logic signed [C+1:0]  dx2_ff;
   logic [C-1:0]         w_ff, h_ff;
   logic [GAIN_BITS-1:0] gain_ff;
   logic                 rz1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         bdx_ff  <= bdx_in;
         bdy_ff  <= bdy_in;
         dx2_ff  <= dx2_in;
         w_ff    <= req_chan.img_width;
         h_ff    <= req_chan.img_height;
         gain_ff <= gain_in;
         rz1_ff  <= rz_in;
      end
   end

   // stage 2: areas and raw gain product
   logic signed [BAW-1:0] barea_in, barea2_ff, barea3_ff;
   logic        [IAW-1:0] iarea_in, iarea_ff;
   logic signed [PW-1:0]  prod_in, prod_ff;
   logic                  rz2_ff, rz3_ff;

   assign barea_in = bdx_ff * bdy_ff;
   assign iarea_in = w_ff * h_ff;
   assign prod_in  = $signed({1'b0, gain_ff}) * dx2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && v1_ff) begin
         barea2_ff <= barea_in;
         iarea_ff  <= iarea_in;
         prod_ff   <= prod_in;
         rz2_ff    <= rz1_ff;
      end
   end

   // stage 3: stop threshold and blended product
   logic        [RHW-1:0] rhs_in, rhs_ff;
   logic signed [SW-1:0]  scaled_in, scaled_ff;

   assign rhs_in    = cfg.stop_area_frac * iarea_ff;
   assign scaled_in = prod_ff * $signed({1'b0, cfg.turn_blend});

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && v2_ff) begin
         barea3_ff <= barea2_ff;
         rhs_ff    <= rhs_in;
         scaled_ff <= scaled_in;
         rz3_ff    <= rz2_ff;
      end
   end

   // stage 4: stop compare, truncate, saturate
   logic signed [LW-1:0] lhs_ext, rhs_ext;
   logic                 stopped;
   logic                 sneg;
   logic [SW-1:0]        sabs;
   logic [MW-1:0]        mag;
   logic [Q15_BITS-1:0]  turn_val, neg_mag;
   logic signed [Q15_BITS-1:0] turn_in, fwd_in, spd_in;

   assign lhs_ext = {barea3_ff[BAW-1], barea3_ff, {AREA_SHIFT{1'b0}}};
   assign rhs_ext = {2'b00, rhs_ff};
   assign stopped = lhs_ext > rhs_ext;

   assign sneg    = scaled_ff[SW-1];
   assign sabs    = sneg ? -scaled_ff : scaled_ff;
   assign mag     = sabs[SW-1:TURN_SHIFT];
   assign neg_mag = -mag[Q15_BITS-1:0];

   always_comb begin
      if (sneg) begin
         turn_val = (mag > MW'(Q15_POS_MAX)) ? Q15_POS_MAX : mag[Q15_BITS-1:0];
      end else begin
         turn_val = (mag >= MW'(Q15_NEG_MAX)) ? Q15_NEG_MAX : neg_mag;
      end
   end

   always_comb begin
      if (rz3_ff && stopped) begin
         turn_in = $signed(Q15_ZERO);
         fwd_in  = $signed(Q15_ZERO);
         spd_in  = $signed(Q15_ZERO);
      end else begin
         turn_in = rz3_ff ? $signed(Q15_ZERO) : $signed(turn_val);
         fwd_in  = stopped ? $signed(Q15_ZERO) : cfg.forward_frac;
         spd_in  = cfg.max_speed;
      end
   end

   logic signed [Q15_BITS-1:0] turn_ff, fwd_ff, spd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4 && v3_ff) begin
         turn_ff <= turn_in;
         fwd_ff  <= fwd_in;
         spd_ff  <= spd_in;
      end
   end

   assign rsp_chan.valid       = v4_ff;
   assign rsp_chan.turn_cmd    = turn_ff;
   assign rsp_chan.forward_cmd = fwd_ff;
   assign rsp_chan.speed_cmd   = spd_ff;

   a_take_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_take |=> v1_ff)
      else $error("accepted item missing from first stage");

   a_s3_to_s4: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && en4) |=> v4_ff)
      else $error("item lost between third stage and result register");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !en3) |=> (v2_ff && $stable(prod_ff) && $stable(iarea_ff)))
      else $error("stalled second stage did not hold its item");

endmodule
